@@ rtl/bcgk_pkg.sv @@
// ----------------------------------------------------------------------------
// bcgk_pkg
// Shared codes, field widths and default sizes for the bucket-chain
// group-by-key block.
// ----------------------------------------------------------------------------
package bcgk_pkg;

  localparam int KEYS_DEFAULT          = 1024;
  localparam int SLOTS_DEFAULT         = 4096;
  localparam int PAYLOAD_WIDTH_DEFAULT = 64;

  localparam int MODE_W       = 2;
  localparam int KEY_W        = 10;
  localparam int PAYLOAD_W    = 64;
  localparam int STATUS_W     = 2;
  localparam int SLOT_W       = 12;
  localparam int COUNT_W      = 13;
  localparam int POSITION_W   = 12;
  localparam int DRAIN_POS_W  = 13;
  localparam int KEYS_IN_USE_W = 11;

  localparam logic [KEYS_IN_USE_W-1:0] KEYS_IN_USE_RESET = 11'd1024;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_KEY_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd3;

endpackage

@@ rtl/bucket_chain_group_by_key.sv @@
// ----------------------------------------------------------------------------
// bucket_chain_group_by_key
// Groups items by key in per-key linked chains held in a slot store and
// drains them in key order, arrival order kept within each key.
// ----------------------------------------------------------------------------
// One word is taken at a time. An append first reads the key table, then
// updates head, tail and count with the payload and link writes in S_APP.
// A read inside a chain reads the key table, link and payload, then gives
// the result in S_RD. Moving to a new key passes S_SCAN and S_SCAN_CHK
// per key examined, since the drain checks one key-table entry per read.
// Clear and the unused mode pass through S_FIX. After reset and after
// each clear the key table is swept, one entry a cycle, over all KEYS entries
// while no word is taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module bucket_chain_group_by_key #(
  parameter int KEYS          = bcgk_pkg::KEYS_DEFAULT,
  parameter int SLOTS         = bcgk_pkg::SLOTS_DEFAULT,
  parameter int PAYLOAD_WIDTH = bcgk_pkg::PAYLOAD_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bcgk_pkg::KEYS_IN_USE_W-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bcgk_pkg::MODE_W-1:0]         mode,
  input  logic [bcgk_pkg::KEY_W-1:0]          key,
  input  logic [bcgk_pkg::PAYLOAD_W-1:0]      payload,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bcgk_pkg::STATUS_W-1:0]       status,
  output logic [bcgk_pkg::SLOT_W-1:0]         slot,
  output logic [bcgk_pkg::KEY_W-1:0]          out_key,
  output logic [bcgk_pkg::PAYLOAD_W-1:0]      out_payload,
  output logic [bcgk_pkg::COUNT_W-1:0]        chain_count,
  output logic [bcgk_pkg::POSITION_W-1:0]     sorted_position,
  output logic                                first_of_key,
  output logic                                last_of_key
);

  localparam int KEY_AW  = $clog2(KEYS);
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int SLOT_CW = $clog2(SLOTS + 1);
  localparam int KCW     = $clog2(KEYS + 1);
  localparam int CNT_W   = (KCW > bcgk_pkg::KEYS_IN_USE_W) ? KCW : bcgk_pkg::KEYS_IN_USE_W;

  localparam logic [2:0] S_SWEEP    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_APP      = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_SCAN_CHK = 3'd4;
  localparam logic [2:0] S_RD       = 3'd5;
  localparam logic [2:0] S_FIX      = 3'd6;

  typedef struct packed {
    logic [SLOT_CW-1:0] len;
    logic [SLOT_AW-1:0] head;
    logic [SLOT_AW-1:0] tail;
  } key_entry_t;

  key_entry_t               key_mem [KEYS];
  logic [SLOT_AW-1:0]       link_mem [SLOTS];
  logic [PAYLOAD_WIDTH-1:0] pay_mem [SLOTS];

  logic [2:0]                            state;
  logic [KEY_AW-1:0]                     sweep_addr;
  logic [bcgk_pkg::KEYS_IN_USE_W-1:0]    keys_in_use;
  logic [SLOT_CW-1:0]                    items_stored;
  logic [CNT_W-1:0]                      drain_key;
  logic [SLOT_AW-1:0]                    drain_slot;
  logic                                  drain_valid;
  logic [bcgk_pkg::DRAIN_POS_W-1:0]      drain_position;
  logic [bcgk_pkg::KEY_W-1:0]            item_key;
  logic [PAYLOAD_WIDTH-1:0]              item_payload;
  logic [bcgk_pkg::STATUS_W-1:0]         fix_status;
  logic                                  fix_clear;

  key_entry_t               kd;
  logic [SLOT_AW-1:0]       link_rd_data;
  logic [PAYLOAD_WIDTH-1:0] pay_rd_data;

  logic [CNT_W-1:0]         limit;
  logic                     accept;
  logic                     out_free;
  logic                     out_load;
  logic                     key_ok;
  logic                     full;
  logic [SLOT_AW-1:0]       s_new;
  logic [SLOT_CW-1:0]       len_inc;
  logic                     app_store;
  logic                     drain_in_range;
  logic                     rd_last;
  logic                     scan_hit;

  logic                     key_rd_en;
  logic [KEY_AW-1:0]        key_rd_addr;
  logic                     key_wr_en;
  logic [KEY_AW-1:0]        key_wr_addr;
  key_entry_t               key_wr_data;
  logic                     slot_rd_en;
  logic [SLOT_AW-1:0]       slot_rd_addr;
  logic                     link_wr_en;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    limit = (CNT_W'(keys_in_use) < CNT_W'(KEYS)) ? CNT_W'(keys_in_use) : CNT_W'(KEYS);
    key_ok = CNT_W'(item_key) < limit;
    full = (items_stored == SLOT_CW'(SLOTS));
    s_new = SLOT_AW'(items_stored);
    len_inc = kd.len + 1'b1;
    app_store = (state == S_APP) && out_free && key_ok && !full;
    out_load = out_free && (state == S_APP || state == S_RD || state == S_FIX);
    drain_in_range = drain_key < limit;
    rd_last = (kd.tail == drain_slot);
    scan_hit = (state == S_SCAN_CHK) && (kd.len != '0);

    key_rd_en = 1'b0;
    key_rd_addr = KEY_AW'(drain_key);
    slot_rd_en = 1'b0;
    slot_rd_addr = drain_slot;
    if (accept && mode == bcgk_pkg::MODE_APPEND) begin
      key_rd_en = 1'b1;
      key_rd_addr = KEY_AW'(key);
    end
    if (accept && mode == bcgk_pkg::MODE_READ && drain_valid && drain_in_range) begin
      key_rd_en = 1'b1;
      slot_rd_en = 1'b1;
    end
    if (state == S_SCAN && drain_in_range) begin
      key_rd_en = 1'b1;
    end
    if (scan_hit) begin
      slot_rd_en = 1'b1;
      slot_rd_addr = kd.head;
    end

    key_wr_en = 1'b0;
    key_wr_addr = sweep_addr;
    key_wr_data = '0;
    if (state == S_SWEEP) begin
      key_wr_en = 1'b1;
    end else if (app_store) begin
      key_wr_en = 1'b1;
      key_wr_addr = KEY_AW'(item_key);
      key_wr_data.len = len_inc;
      key_wr_data.head = (kd.len == '0) ? s_new : kd.head;
      key_wr_data.tail = s_new;
    end
    link_wr_en = app_store && (kd.len != '0);
  end

  always_ff @(posedge clk) begin
    if (key_wr_en) begin
      key_mem[key_wr_addr] <= key_wr_data;
    end
    if (key_rd_en) begin
      kd <= key_mem[key_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (link_wr_en) begin
      link_mem[kd.tail] <= s_new;
    end
    if (slot_rd_en) begin
      link_rd_data <= link_mem[slot_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (app_store) begin
      pay_mem[s_new] <= item_payload;
    end
    if (slot_rd_en) begin
      pay_rd_data <= pay_mem[slot_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      sweep_addr <= '0;
      keys_in_use <= bcgk_pkg::KEYS_IN_USE_RESET;
      items_stored <= '0;
      drain_key <= '0;
      drain_valid <= 1'b0;
      drain_position <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        keys_in_use <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == KEY_AW'(KEYS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item_key <= key;
            item_payload <= PAYLOAD_WIDTH'(payload);
            fix_clear <= (mode == bcgk_pkg::MODE_CLEAR);
            case (mode)
              bcgk_pkg::MODE_CLEAR: begin
                fix_status <= bcgk_pkg::STATUS_OK;
                state <= S_FIX;
              end
              bcgk_pkg::MODE_APPEND: begin
                fix_status <= bcgk_pkg::STATUS_OK;
                state <= S_APP;
              end
              bcgk_pkg::MODE_READ: begin
                if (!drain_valid) begin
                  fix_status <= bcgk_pkg::STATUS_OK;
                  state <= S_SCAN;
                end else if (drain_in_range) begin
                  fix_status <= bcgk_pkg::STATUS_OK;
                  state <= S_RD;
                end else begin
                  fix_status <= bcgk_pkg::STATUS_DONE;
                  state <= S_FIX;
                end
              end
              default: begin
                fix_status <= bcgk_pkg::STATUS_OK;
                state <= S_FIX;
              end
            endcase
          end
        end
        S_APP: begin
          if (out_free) begin
            out_key <= '0;
            out_payload <= '0;
            sorted_position <= '0;
            first_of_key <= 1'b0;
            last_of_key <= 1'b0;
            if (!key_ok) begin
              status <= bcgk_pkg::STATUS_KEY_RANGE;
              slot <= '0;
              chain_count <= '0;
            end else if (full) begin
              status <= bcgk_pkg::STATUS_FULL;
              slot <= '0;
              chain_count <= bcgk_pkg::COUNT_W'(kd.len);
            end else begin
              status <= bcgk_pkg::STATUS_OK;
              slot <= bcgk_pkg::SLOT_W'(s_new);
              chain_count <= bcgk_pkg::COUNT_W'(len_inc);
              items_stored <= items_stored + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (drain_in_range) begin
            state <= S_SCAN_CHK;
          end else begin
            fix_status <= bcgk_pkg::STATUS_DONE;
            state <= S_FIX;
          end
        end
        S_SCAN_CHK: begin
          if (scan_hit) begin
            drain_slot <= kd.head;
            drain_valid <= 1'b1;
            state <= S_RD;
          end else begin
            drain_key <= drain_key + 1'b1;
            state <= S_SCAN;
          end
        end
        S_RD: begin
          if (out_free) begin
            status <= bcgk_pkg::STATUS_OK;
            slot <= bcgk_pkg::SLOT_W'(drain_slot);
            out_key <= bcgk_pkg::KEY_W'(drain_key);
            out_payload <= bcgk_pkg::PAYLOAD_W'(pay_rd_data);
            chain_count <= '0;
            sorted_position <= bcgk_pkg::POSITION_W'(drain_position);
            first_of_key <= (kd.len != '0) && (kd.head == drain_slot);
            last_of_key <= rd_last;
            drain_position <= drain_position + 1'b1;
            if (rd_last) begin
              drain_valid <= 1'b0;
              drain_key <= drain_key + 1'b1;
            end else begin
              drain_slot <= link_rd_data;
            end
            state <= S_IDLE;
          end
        end
        S_FIX: begin
          if (out_free) begin
            status <= fix_status;
            slot <= '0;
            out_key <= '0;
            out_payload <= '0;
            chain_count <= '0;
            sorted_position <= '0;
            first_of_key <= 1'b0;
            last_of_key <= 1'b0;
            if (fix_clear) begin
              items_stored <= '0;
              drain_key <= '0;
              drain_valid <= 1'b0;
              drain_position <= '0;
              sweep_addr <= '0;
              state <= S_SWEEP;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_items_bound: assert property (@(posedge clk) disable iff (rst)
    items_stored <= SLOT_CW'(SLOTS))
    else $error("slot store count beyond capacity");

  a_drain_key: assert property (@(posedge clk) disable iff (rst)
    drain_valid |-> drain_key < CNT_W'(KEYS))
    else $error("drain walking a key outside the table");

  a_store_count: assert property (@(posedge clk) disable iff (rst)
    app_store |=> items_stored == SLOT_CW'($past(items_stored) + 1'b1))
    else $error("append did not advance the slot count");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_APP || $past(state) == S_RD ||
                          $past(state) == S_FIX))
    else $error("result word from a state that produces none");

endmodule
